>>> sv/stkpol_pkg.sv
package stkpol_pkg;

	// Widths of the item fields
	localparam int SAMPLE_W = 8;
	localparam int SUM_W    = 10;
	localparam int Q14_W    = 16;

	// Pipeline geometry: one cell per step of the division followed by the square root
	localparam int CORDIC_STEPS = 20;
	localparam int SDIV_STEPS   = 16;
	localparam int DDIV_STEPS   = 33;
	localparam int SQRT_STEPS   = 17;
	localparam int NUM_CELLS    = DDIV_STEPS + SQRT_STEPS;

	// Fixed-point angle constants
	localparam int PI_Q20      = 3294199;
	localparam int TWO_PI_Q20  = 6588398;
	localparam int HALF_PI_Q14 = 25736;
	localparam int AOLP_MAX    = 51471;

	localparam logic signed [24:0] ATAN_Q20 [0:CORDIC_STEPS-1] = '{
		25'sd823550, 25'sd486170, 25'sd256879, 25'sd130396, 25'sd65451,
		25'sd32757, 25'sd16383, 25'sd8192, 25'sd4096, 25'sd2048,
		25'sd1024, 25'sd512, 25'sd256, 25'sd128, 25'sd64,
		25'sd32, 25'sd16, 25'sd8, 25'sd4, 25'sd2
	};

	// Polarizer angle codes
	localparam logic [1:0] ANG_0   = 2'd0;
	localparam logic [1:0] ANG_45  = 2'd1;
	localparam logic [1:0] ANG_90  = 2'd2;
	localparam logic [1:0] ANG_135 = 2'd3;

	// Register indexes
	localparam logic [1:0] REG_R0C0 = 2'd0;
	localparam logic [1:0] REG_R1C0 = 2'd1;
	localparam logic [1:0] REG_R0C1 = 2'd2;
	localparam logic [1:0] REG_R1C1 = 2'd3;

	typedef logic [3:0][1:0] codes_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_r0c0;
		logic [SAMPLE_W-1:0] sample_r1c0;
		logic [SAMPLE_W-1:0] sample_r0c1;
		logic [SAMPLE_W-1:0] sample_r1c1;
	} pix_t;

	typedef struct packed {
		logic [SUM_W-1:0]        intensity_sum;
		logic [7:0]              intensity_byte;
		logic signed [Q14_W-1:0] stokes_s1;
		logic signed [Q14_W-1:0] stokes_s2;
		logic [Q14_W-1:0]        angle_of_polarization;
		logic [Q14_W-1:0]        degree_of_polarization;
		logic                    bad_mapping;
	} res_t;

	// State of one item as it travels along the cells
	typedef struct packed {
		logic [SUM_W-1:0]    sum;
		logic                bad;
		logic                neg_dx;
		logic                neg_dy;
		logic                dy_zero;
		logic                q_lsb;
		logic [10:0]         rem_s1;
		logic [15:0]         quo_s1;
		logic [10:0]         rem_s2;
		logic [15:0]         quo_s2;
		logic [19:0]         sq_sum;
		logic [19:0]         rem_dl;
		logic [32:0]         quo_dl;
		logic [18:0]         rem_rt;
		logic [16:0]         root;
		logic signed [27:0]  cx;
		logic signed [27:0]  cy;
		logic signed [24:0]  cz;
	} cell_t;

endpackage

>>> sv/stkpol_cfg.sv
module stkpol_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output stkpol_pkg::codes_t    codes
);
	import stkpol_pkg::*;

	codes_t codes_q;
	logic   wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign codes  = codes_q;

	// Write the addressed angle code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q[REG_R0C0] <= ANG_0;
			codes_q[REG_R1C0] <= ANG_45;
			codes_q[REG_R0C1] <= ANG_90;
			codes_q[REG_R1C1] <= ANG_135;
		end else if (wr_en) begin
			codes_q[paddr[3:2]] <= pwdata[1:0];
		end
	end

	// Read back the addressed code
	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_R0C0: prdata[1:0] = codes_q[REG_R0C0];
			REG_R1C0: prdata[1:0] = codes_q[REG_R1C0];
			REG_R0C1: prdata[1:0] = codes_q[REG_R0C1];
			REG_R1C1: prdata[1:0] = codes_q[REG_R1C1];
			default:  prdata = '0;
		endcase
	end

endmodule

>>> sv/stkpol_prep.sv
module stkpol_prep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 pix_valid,
	input  stkpol_pkg::pix_t     pix,
	input  stkpol_pkg::codes_t   codes,
	output logic                 st_valid,
	output stkpol_pkg::cell_t    st
);
	import stkpol_pkg::*;

	logic [3:0][SAMPLE_W-1:0] smp;
	logic [3:0][SAMPLE_W-1:0] by_ang;
	logic [3:0]               seen;
	logic [SUM_W-1:0]         sum_c;
	logic signed [8:0]        dx_c, dy_c;

	logic                     v_s1, v_s2;
	logic [SUM_W-1:0]         sum_s1;
	logic                     bad_s1;
	logic signed [8:0]        dx_s1, dy_s1;
	cell_t                    st_c, st_s2;
	logic [16:0]              q_c;
	logic signed [27:0]       x0, y0;

	assign smp = {pix.sample_r1c1, pix.sample_r0c1, pix.sample_r1c0, pix.sample_r0c0};

	// Sort the samples by polarizer angle; later positions win a clash
	always_comb begin
		by_ang = '0;
		seen   = '0;
		for (int i = 0; i < 4; i++) begin
			by_ang[codes[i]] = smp[i];
			seen[codes[i]]   = 1'b1;
		end
		sum_c = SUM_W'(smp[0]) + SUM_W'(smp[1]) + SUM_W'(smp[2]) + SUM_W'(smp[3]);
		dx_c  = $signed({1'b0, by_ang[ANG_0]})  - $signed({1'b0, by_ang[ANG_90]});
		dy_c  = $signed({1'b0, by_ang[ANG_45]}) - $signed({1'b0, by_ang[ANG_135]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum_c;
			bad_s1 <= (seen != 4'hF);
			dx_s1  <= dx_c;
			dy_s1  <= dy_c;
		end
	end

	// Form the squares and the starting values of every unit
	always_comb begin
		q_c = 17'(dx_s1 * dx_s1) + 17'(dy_s1 * dy_s1);
		x0  = 28'(dx_s1) <<< 16;
		y0  = 28'(dy_s1) <<< 16;
		st_c         = '0;
		st_c.sum     = sum_s1;
		st_c.bad     = bad_s1;
		st_c.neg_dx  = dx_s1[8];
		st_c.neg_dy  = dy_s1[8];
		st_c.dy_zero = (dy_s1 == '0);
		st_c.q_lsb   = q_c[0];
		st_c.rem_s1  = 11'(dx_s1[8] ? -dx_s1 : dx_s1);
		st_c.rem_s2  = 11'(dy_s1[8] ? -dy_s1 : dy_s1);
		st_c.sq_sum  = 20'(sum_s1 * sum_s1);
		st_c.rem_dl  = 20'(q_c[16:1]);
		if (dx_s1[8]) begin
			st_c.cx = -x0;
			st_c.cy = -y0;
			st_c.cz = (dy_s1 > 0) ? 25'(PI_Q20) : -25'(PI_Q20);
		end else begin
			st_c.cx = x0;
			st_c.cy = y0;
			st_c.cz = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s2 <= st_c;
		end
	end

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
			v_s2 <= v_s1;
		end
	end

	assign st_valid = v_s2;
	assign st       = st_s2;

endmodule

>>> sv/stkpol_cell.sv
module stkpol_cell #(
	parameter int K = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  stkpol_pkg::cell_t    st_in,
	output logic                 out_valid,
	output stkpol_pkg::cell_t    st_out
);
	import stkpol_pkg::*;

	logic signed [27:0] cx_n, cy_n;
	logic signed [24:0] cz_n;
	logic [10:0]        rem_s1_n, rem_s2_n;
	logic [15:0]        quo_s1_n, quo_s2_n;
	logic [19:0]        rem_dl_n;
	logic [32:0]        quo_dl_n;
	logic [18:0]        rem_rt_n;
	logic [16:0]        root_n;
	cell_t              nxt;
	cell_t              st_q;
	logic               valid_q;

	// One CORDIC rotation toward the x axis
	if (K < CORDIC_STEPS) begin : g_cordic
		logic signed [27:0] xs, ys;
		assign xs = st_in.cx >>> K;
		assign ys = st_in.cy >>> K;
		always_comb begin
			if (!st_in.cy[27]) begin
				cx_n = st_in.cx + ys;
				cy_n = st_in.cy - xs;
				cz_n = st_in.cz + ATAN_Q20[K];
			end else begin
				cx_n = st_in.cx - ys;
				cy_n = st_in.cy + xs;
				cz_n = st_in.cz - ATAN_Q20[K];
			end
		end
	end else begin : g_cordic_hold
		assign cx_n = st_in.cx;
		assign cy_n = st_in.cy;
		assign cz_n = st_in.cz;
	end

	// One quotient bit of each Stokes division by twice the sum
	if (K < SDIV_STEPS) begin : g_sdiv
		localparam int J = SDIV_STEPS - 1 - K;
		logic        nb;
		logic [11:0] dv, t1, t2;
		if (J < SUM_W) begin : g_bit
			assign nb = st_in.sum[J];
		end else begin : g_zero
			assign nb = 1'b0;
		end
		assign dv       = {1'b0, st_in.sum, 1'b0};
		assign t1       = {st_in.rem_s1, nb};
		assign t2       = {st_in.rem_s2, nb};
		assign rem_s1_n = (t1 >= dv) ? 11'(t1 - dv) : t1[10:0];
		assign rem_s2_n = (t2 >= dv) ? 11'(t2 - dv) : t2[10:0];
		assign quo_s1_n = {st_in.quo_s1[14:0], t1 >= dv};
		assign quo_s2_n = {st_in.quo_s2[14:0], t2 >= dv};
	end else begin : g_sdiv_hold
		assign rem_s1_n = st_in.rem_s1;
		assign rem_s2_n = st_in.rem_s2;
		assign quo_s1_n = st_in.quo_s1;
		assign quo_s2_n = st_in.quo_s2;
	end

	// One quotient bit of the squared-magnitude division
	if (K < DDIV_STEPS) begin : g_ddiv
		logic        nb;
		logic [20:0] dv, t;
		assign nb       = (K == 0) ? st_in.q_lsb : 1'b0;
		assign dv       = {1'b0, st_in.sq_sum};
		assign t        = {st_in.rem_dl, nb};
		assign rem_dl_n = (t >= dv) ? 20'(t - dv) : t[19:0];
		assign quo_dl_n = {st_in.quo_dl[31:0], t >= dv};
	end else begin : g_ddiv_hold
		assign rem_dl_n = st_in.rem_dl;
		assign quo_dl_n = st_in.quo_dl;
	end

	// One root bit of the square root, two operand bits a cell
	if (K >= DDIV_STEPS) begin : g_sqrt
		localparam int P = NUM_CELLS - 1 - K;
		logic [33:0] op;
		logic [20:0] t, trial;
		assign op       = {1'b0, st_in.quo_dl};
		assign t        = {st_in.rem_rt, op[2*P+1:2*P]};
		assign trial    = {2'b00, st_in.root, 2'b01};
		assign rem_rt_n = (t >= trial) ? 19'(t - trial) : t[18:0];
		assign root_n   = {st_in.root[15:0], t >= trial};
	end else begin : g_sqrt_hold
		assign rem_rt_n = st_in.rem_rt;
		assign root_n   = st_in.root;
	end

	always_comb begin
		nxt        = st_in;
		nxt.cx     = cx_n;
		nxt.cy     = cy_n;
		nxt.cz     = cz_n;
		nxt.rem_s1 = rem_s1_n;
		nxt.rem_s2 = rem_s2_n;
		nxt.quo_s1 = quo_s1_n;
		nxt.quo_s2 = quo_s2_n;
		nxt.rem_dl = rem_dl_n;
		nxt.quo_dl = quo_dl_n;
		nxt.rem_rt = rem_rt_n;
		nxt.root   = root_n;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	assign out_valid = valid_q;
	assign st_out    = st_q;

endmodule

>>> sv/stkpol_out.sv
module stkpol_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  stkpol_pkg::cell_t    st,
	output logic                 en,
	output logic                 res_valid,
	input  logic                 res_ready,
	output stkpol_pkg::res_t     res
);
	import stkpol_pkg::*;

	res_t               fin;
	logic               zero_out;
	logic [SUM_W:0]     ib;
	logic signed [25:0] ang;
	logic [18:0]        rnd;
	logic [17:0]        dl;
	logic               push, pop;
	logic               out_valid_q, skid_valid_q;
	res_t               out_q, skid_q;

	// Round, saturate and mask the finished item
	always_comb begin
		zero_out = st.bad || (st.sum == '0);
		ib       = ({1'b0, st.sum} + 11'd1) >> 1;
		ang      = 26'(st.cz) + (st.neg_dy ? 26'(TWO_PI_Q20) : 26'd0);
		rnd      = ang[25] ? 19'd0 : 19'((ang + 26'sd64) >>> 7);
		dl       = ({1'b0, st.root} + 18'd1) >> 1;

		fin                = '0;
		fin.intensity_sum  = st.sum;
		fin.intensity_byte = (ib > 11'd255) ? 8'd255 : ib[7:0];
		fin.bad_mapping    = st.bad;
		if (!zero_out) begin
			if (st.neg_dx)
				fin.stokes_s1 = -$signed(st.quo_s1);
			else
				fin.stokes_s1 = st.quo_s1[15] ? 16'sh7FFF : $signed(st.quo_s1);
			if (st.neg_dy)
				fin.stokes_s2 = -$signed(st.quo_s2);
			else
				fin.stokes_s2 = st.quo_s2[15] ? 16'sh7FFF : $signed(st.quo_s2);
			if (st.dy_zero)
				fin.angle_of_polarization = st.neg_dx ? 16'(HALF_PI_Q14) : 16'd0;
			else if (rnd > 19'(AOLP_MAX))
				fin.angle_of_polarization = 16'(AOLP_MAX);
			else
				fin.angle_of_polarization = rnd[15:0];
			fin.degree_of_polarization = dl[17:16] != 2'b00 ? 16'hFFFF : dl[15:0];
		end
	end

	// Output register with a skid entry behind it
	assign en   = !skid_valid_q;
	assign push = en && in_valid;
	assign pop  = out_valid_q && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!push) begin
				out_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push)
				out_q <= fin;
		end else if (push) begin
			if (out_valid_q)
				skid_q <= fin;
			else
				out_q <= fin;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output item");

	a_refill_from_skid: assert property (@(posedge clk) disable iff (!arst_n)
		pop && skid_valid_q |=> out_valid_q && !skid_valid_q)
		else $error("skid item not moved to output");

	a_bad_masks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.bad_mapping |-> out_q.stokes_s1 == '0 &&
		out_q.stokes_s2 == '0 && out_q.angle_of_polarization == '0 &&
		out_q.degree_of_polarization == '0)
		else $error("bad mapping item carries non-zero fields");

	a_aolp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.angle_of_polarization <= 16'(AOLP_MAX))
		else $error("angle beyond pi");

endmodule

>>> sv/stokes_aolp_dolp_pixel.sv
// Linear Stokes polarimetry for one 2x2 polarizer superpixel per item.
// pix channel (valid/ready): four 8-bit samples; the four angle codes set
// over the APB port say which polarizer angle each mosaic position carries.
// res channel (valid/ready): sum, 8-bit intensity, normalised S1 and S2,
// AoLP and DoLP in 14-bit fraction fixed point, and a flag when the codes
// are not a permutation.
// Path from an accepted item to res_valid: two set-up stages, a row of 50
// cells, one output register. The row length is set by the
// 33-bit division and 17-bit square root behind DoLP; the CORDIC and the
// Stokes divisions ride the same cells.
// Throughput: one item per cycle while the row is not held; each cell takes at most one step of each unit.
// Receiver stall: the output register holds its item and a skid entry takes
// one more; only when that entry fills does the whole row hold and pix_ready
// fall. pix_ready depends on registered state only.
// Reset: the row and output empty at once, angle codes return to 0,1,2,3.
// The user must write configuration only while no item is in flight; the block does not enforce this.
module stokes_aolp_dolp_pixel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_ready,
	input  stkpol_pkg::pix_t    pix,
	output logic                res_valid,
	input  logic                res_ready,
	output stkpol_pkg::res_t    res,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import stkpol_pkg::*;

	codes_t codes;
	logic   en;
	logic   vld [0:NUM_CELLS];
	cell_t  st  [0:NUM_CELLS];

	stkpol_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.codes   (codes)
	);

	stkpol_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.pix_valid (pix_valid),
		.pix       (pix),
		.codes     (codes),
		.st_valid  (vld[0]),
		.st        (st[0])
	);

	// Row of step cells
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_row
		stkpol_cell #(.K(k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld[k]),
			.st_in     (st[k]),
			.out_valid (vld[k+1]),
			.st_out    (st[k+1])
		);
	end

	stkpol_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[NUM_CELLS]),
		.st        (st[NUM_CELLS]),
		.en        (en),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign pix_ready = en;

endmodule
